// ===== sv/sbm_pkg.sv =====
// shared types for the scrambled bank mapper
package sbm_pkg;

  // one input transaction: a cpu write or a scanline tick
  typedef struct packed {
    logic        action;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } sbm_item_t;

  // full bank map and irq line after one transaction
  typedef struct packed {
    logic [7:0][7:0] chr_bank;
    logic [7:0]      prg_bank_low;
    logic [7:0]      prg_bank_high;
    logic            mirror_horizontal;
    logic            irq_line;
  } sbm_result_t;

  // configuration register contents
  typedef struct packed {
    logic [8:0] prg_bank_count;
    logic       four_screen;
  } sbm_cfg_t;

  // input kind carried on tuser
  localparam logic ActWrite = 1'b0;
  localparam logic ActTick  = 1'b1;

  // widths of the packed stream buses
  localparam int InDataW  = 40;
  localparam int OutDataW = 88;

endpackage

// ===== sv/sbm_cfg.sv =====
// apb configuration registers
module sbm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sbm_pkg::sbm_cfg_t cfg
);

  localparam logic RegPrgBankCount = 1'b0;
  localparam logic RegFourScreen   = 1'b1;

  logic [8:0] prg_bank_count;
  logic       four_screen;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= 9'd32;
      four_screen    <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        RegPrgBankCount: prg_bank_count <= pwdata[8:0];
        RegFourScreen:   four_screen    <= pwdata[0];
        default:         ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      RegPrgBankCount: prdata = {23'd0, prg_bank_count};
      RegFourScreen:   prdata = {31'd0, four_screen};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.prg_bank_count = prg_bank_count;
  assign cfg.four_screen    = four_screen;

endmodule

// ===== sv/sbm_in_stage.sv =====
// input register stage: unpacks the slave stream into an item
module sbm_in_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sbm_pkg::InDataW-1:0]  s_tdata,
  input  logic                         s_tuser,
  input  logic                         advance,
  output logic                         item_valid,
  output sbm_pkg::sbm_item_t           item
);

  logic take;

  assign s_tready = !item_valid || advance;
  assign take     = s_tvalid && s_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      item.action       <= s_tuser;
      item.addr         <= s_tdata[15:0];
      item.data         <= s_tdata[23:16];
      item.scanline     <= s_tdata[32:24];
      item.rendering_on <= s_tdata[33];
    end
  end

endmodule

// ===== sv/sbm_mapper.sv =====
// mapper state: bank registers, scramble mode and scanline irq counter
module sbm_mapper #(
  parameter int VISIBLE_LINES = 240
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  sbm_pkg::sbm_item_t  item,
  input  sbm_pkg::sbm_cfg_t   cfg,
  output sbm_pkg::sbm_result_t result
);

  localparam logic [8:0] VisLines = 9'(VISIBLE_LINES);

  localparam logic [15:0] ScrambleAddr = 16'h5000;
  localparam logic [15:0] DecodeMask   = 16'hFF01;
  localparam logic [15:0] DecSelA      = 16'h8000;
  localparam logic [15:0] DecSelB      = 16'h8800;
  localparam logic [15:0] DecBankA     = 16'h8001;
  localparam logic [15:0] DecBankB     = 16'h8801;
  localparam logic [15:0] DecMirrorA   = 16'hA000;
  localparam logic [15:0] DecMirrorB   = 16'hA800;
  localparam logic [15:0] DecCountA    = 16'hC000;
  localparam logic [15:0] DecCountB    = 16'hC800;
  localparam logic [15:0] DecReloadA   = 16'hC001;
  localparam logic [15:0] DecReloadB   = 16'hC801;
  localparam logic [15:0] DecIrqOffA   = 16'hE000;
  localparam logic [15:0] DecIrqOffB   = 16'hE800;
  localparam logic [15:0] DecIrqOnA    = 16'hE001;
  localparam logic [15:0] DecIrqOnB    = 16'hE801;

  localparam logic [7:0] ScrambleOff = 8'h00;
  localparam logic [7:0] ScrambleOn  = 8'h02;
  localparam logic [7:0] PrgOffset   = 8'h20;
  localparam logic [7:0] EvenMask    = 8'hFE;
  localparam logic [2:0] CmdMask     = 3'h7;

  localparam logic [2:0] CmdChr01   = 3'd0;
  localparam logic [2:0] CmdChr23   = 3'd1;
  localparam logic [2:0] CmdChr4    = 3'd2;
  localparam logic [2:0] CmdChr5    = 3'd3;
  localparam logic [2:0] CmdChr6    = 3'd4;
  localparam logic [2:0] CmdChr7    = 3'd5;
  localparam logic [2:0] CmdPrgLow  = 3'd6;
  localparam logic [2:0] CmdPrgHigh = 3'd7;

  // full byte bit permutation
  function automatic logic [7:0] permute_full(input logic [7:0] d);
    permute_full = {d[5], d[4], d[2], d[6], d[7], d[3], d[1], d[0]};
  endfunction

  logic [2:0]      command_select, command_select_next;
  logic            scramble_on, scramble_on_next;
  logic [7:0][7:0] pattern_banks, pattern_banks_next;
  logic [7:0]      prg_low, prg_low_next;
  logic [7:0]      prg_high, prg_high_next;
  logic            mirror_mode, mirror_mode_next;
  logic [7:0]      line_counter, line_counter_next;
  logic [7:0]      reload_value, reload_value_next;
  logic            irq_enabled, irq_enabled_next;
  logic            irq_pending, irq_pending_next;

  // next state for one transaction
  always_comb begin
    logic [15:0] dec;
    logic [7:0]  chr_val;
    logic [7:0]  prg_sub;
    logic [7:0]  prg_val;
    logic [7:0]  cnt;

    command_select_next = command_select;
    scramble_on_next    = scramble_on;
    pattern_banks_next  = pattern_banks;
    prg_low_next        = prg_low;
    prg_high_next       = prg_high;
    mirror_mode_next    = mirror_mode;
    line_counter_next   = line_counter;
    reload_value_next   = reload_value;
    irq_enabled_next    = irq_enabled;
    irq_pending_next    = irq_pending;

    dec     = item.addr & DecodeMask;
    chr_val = scramble_on ? permute_full(item.data) : item.data;
    prg_sub = item.data - PrgOffset;
    if (!scramble_on) begin
      prg_val = item.data;
    end else if (item.data < PrgOffset) begin
      prg_val = {3'd0, item.data[2], item.data[1], item.data[3], item.data[4], item.data[0]};
    end else begin
      prg_val = permute_full(prg_sub);
    end

    // line zero takes one extra step off a nonzero counter
    cnt = line_counter;
    if (item.scanline == 9'd0 && line_counter != 8'd0) begin
      cnt = line_counter - 8'd1;
    end

    if (item.action == sbm_pkg::ActWrite) begin
      if (item.addr == ScrambleAddr) begin
        if (item.data == ScrambleOff) begin
          scramble_on_next = 1'b0;
        end else if (item.data == ScrambleOn) begin
          scramble_on_next = 1'b1;
        end
      end else begin
        case (dec)
          DecSelA, DecSelB: begin
            command_select_next = item.data[2:0] & CmdMask;
          end
          DecBankA, DecBankB: begin
            case (command_select)
              CmdChr01: begin
                pattern_banks_next[0] = chr_val & EvenMask;
                pattern_banks_next[1] = chr_val | 8'h01;
              end
              CmdChr23: begin
                pattern_banks_next[2] = chr_val & EvenMask;
                pattern_banks_next[3] = chr_val | 8'h01;
              end
              CmdChr4: pattern_banks_next[4] = chr_val;
              CmdChr5: pattern_banks_next[5] = chr_val;
              CmdChr6: pattern_banks_next[6] = chr_val;
              CmdChr7: pattern_banks_next[7] = chr_val;
              CmdPrgLow: prg_low_next = prg_val;
              CmdPrgHigh: prg_high_next = prg_val;
              default: ;
            endcase
          end
          DecMirrorA, DecMirrorB: begin
            if (!cfg.four_screen) begin
              mirror_mode_next = item.data[0];
            end
          end
          DecCountA, DecCountB: begin
            line_counter_next = item.data;
            irq_pending_next  = 1'b0;
          end
          DecReloadA, DecReloadB: begin
            reload_value_next = item.data;
            irq_pending_next  = 1'b0;
          end
          DecIrqOffA, DecIrqOffB: begin
            irq_enabled_next = 1'b0;
            irq_pending_next = 1'b0;
          end
          DecIrqOnA, DecIrqOnB: begin
            irq_enabled_next = 1'b1;
            irq_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
    end else if (item.scanline < VisLines && item.rendering_on &&
                 irq_enabled && !irq_pending) begin
      // counting scanline tick
      if (cnt == 8'd0) begin
        irq_pending_next  = 1'b1;
        line_counter_next = reload_value;
      end else begin
        line_counter_next = cnt - 8'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command_select <= 3'd0;
      scramble_on    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        pattern_banks[i] <= 8'(i);
      end
      prg_low        <= 8'd0;
      prg_high       <= 8'd1;
      mirror_mode    <= 1'b0;
      line_counter   <= 8'd0;
      reload_value   <= 8'd0;
      irq_enabled    <= 1'b0;
      irq_pending    <= 1'b0;
    end else if (advance) begin
      command_select <= command_select_next;
      scramble_on    <= scramble_on_next;
      pattern_banks  <= pattern_banks_next;
      prg_low        <= prg_low_next;
      prg_high       <= prg_high_next;
      mirror_mode    <= mirror_mode_next;
      line_counter   <= line_counter_next;
      reload_value   <= reload_value_next;
      irq_enabled    <= irq_enabled_next;
      irq_pending    <= irq_pending_next;
    end
  end

  // result is the state after this transaction
  assign result.chr_bank          = pattern_banks_next;
  assign result.prg_bank_low      = prg_low_next;
  assign result.prg_bank_high     = prg_high_next;
  assign result.mirror_horizontal = mirror_mode_next;
  assign result.irq_line          = irq_pending_next;

endmodule

// ===== sv/sbm_out_stage.sv =====
// result register driving the master stream
module sbm_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  sbm_pkg::sbm_result_t          result,
  output logic                          out_free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sbm_pkg::OutDataW-1:0]  m_tdata
);

  sbm_pkg::sbm_result_t res_q;

  assign out_free = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= result;
    end
  end

  // pack fields, slot 0 bank lowest
  assign m_tdata = {6'd0, res_q.irq_line, res_q.mirror_horizontal,
                    res_q.prg_bank_high, res_q.prg_bank_low, res_q.chr_bank};

endmodule

// ===== sv/scrambled_bank_mapper_with_scanline_irq_core.sv =====
// Scrambled bank mapper with scanline irq: every transaction passes through an input register,
// one pass of decode, permute and counter logic, and a result register, so a transaction is
// accepted every cycle; throughput is set by the update of the mapper state registers, and it
// falls only when the result register is held by a stalled master side.
module scrambled_bank_mapper_with_scanline_irq_core #(
  parameter int VISIBLE_LINES = 240
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  // addr[15:0], data[23:16], scanline[32:24], rendering_on[33], zero pad
  input  logic [39:0] s_tdata,
  // action (0 cpu write, 1 scanline tick)
  input  logic        s_tuser,
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  // chr_bank_0[7:0] .. chr_bank_7[63:56], prg_bank_low[71:64], prg_bank_high[79:72],
  // mirror_horizontal[80], irq_line[81], zero pad
  output logic [87:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sbm_pkg::sbm_item_t   item;
  sbm_pkg::sbm_result_t result;
  sbm_pkg::sbm_cfg_t    cfg;
  logic                 item_valid;
  logic                 out_free;
  logic                 advance;

  assign advance = item_valid && out_free;

  sbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sbm_mapper #(
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_mapper (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  sbm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sv/sbm_checker.sv =====
// port-level checker for the bank mapper, bound to the top level
module sbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // paired slots 0/1 keep an even/odd pair of one bank
  a_chr01_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] && m_tdata[8] && (m_tdata[15:9] == m_tdata[7:1])))
    else $error("slot 0/1 banks are not an even/odd pair");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind scrambled_bank_mapper_with_scanline_irq_core sbm_checker u_sbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
